// File: src/slifr_pkg.sv
// ----------------------------------------------------------------------------
// slifr_pkg
// Shared types and constants of the sorted list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slifr_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int POSITION_W = 4;
  localparam int COUNT_W    = 5;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  // outcome of one compare of a stored entry against the operand
  typedef struct packed {
    logic le;  // entry <= operand, signed
    logic eq;  // entry == operand
  } cmp_t;

endpackage

`default_nettype wire

// File: src/slifr_in_if.sv
// ----------------------------------------------------------------------------
// slifr_in_if
// Request channel: operation and operand, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slifr_in_if import slifr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// File: src/slifr_out_if.sv
// ----------------------------------------------------------------------------
// slifr_out_if
// Result channel: status, position and count, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slifr_out_if import slifr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [POSITION_W-1:0] position;
  logic [COUNT_W-1:0]    count;

  modport source (output valid, output status, output position, output count,
                  input ready);
  modport sink   (input valid, input status, input position, input count,
                  output ready);
endinterface

`default_nettype wire

// File: src/slifr_cmp.sv
// ----------------------------------------------------------------------------
// slifr_cmp
// Shared signed compare unit: one stored entry against the operand.
// ----------------------------------------------------------------------------
`default_nettype none

module slifr_cmp import slifr_pkg::*; (
  input  wire logic signed [VALUE_W-1:0] entry,
  input  wire logic signed [VALUE_W-1:0] key,
  output cmp_t                           result
);

  always_comb begin
    result.le = (entry <= key);
    result.eq = (entry == key);
  end

endmodule

`default_nettype wire

// File: src/sorted_list_insert_find_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_find_remove_unit
// Sorted table of signed 32-bit values with insert, find and remove.
// ----------------------------------------------------------------------------
// The unit keeps up to CAPACITY signed values in ascending order in a
// single-port-read memory, duplicates allowed, and answers every request
// item with exactly one result item. Insert walks from the tail toward the
// head, moving each larger entry up one slot, and drops the operand into the
// gap it reaches, so a new value lands after all equal ones. Find walks from
// the head and stops at the first equal entry. Remove walks from the head as
// well and, once the first equal entry is seen, moves every later entry down
// one slot. Every visited entry takes a memory read state and then a compare
// and write-back state through the one shared compare unit; an insert that
// reaches the head takes a further state to put the operand in slot zero,
// and a finished item waits in the result state until the output register
// is free. req.ready is high only while the unit is idle; a finished result
// may wait in the output register while the next item is accepted. The
// memory is never cleared: only entries below the occupancy count are ever
// read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_find_remove_unit import slifr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  slifr_in_if.sink    req,
  slifr_out_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUT,
    S_RESULT
  } state_t;

  state_t                    state;
  logic [MODE_W-1:0]         op;
  logic signed [VALUE_W-1:0] key;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          pos;
  logic [CNT_W-1:0]          occ;
  logic                      found;
  logic [STATUS_W-1:0]       status;

  logic                      rsp_valid;
  logic [STATUS_W-1:0]       rsp_status;
  logic [POSITION_W-1:0]     rsp_position;
  logic [COUNT_W-1:0]        rsp_count;

  // table storage, read data registered
  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [VALUE_W-1:0] wr_data;

  cmp_t                      cmp;
  logic                      last;
  logic                      accept;

  slifr_cmp u_cmp (
    .entry  (rdata),
    .key    (key),
    .result (cmp)
  );

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // the entry under test is the last occupied one
  assign last = (CNT_W'(idx) == (occ - CNT_W'(1)));

  // Write port: insert moves entries up (or drops the key into place),
  // remove moves entries down once the match is behind the scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rdata;
    unique case (state)
      S_EVAL: begin
        if (op == MODE_INSERT) begin
          wr_en   = 1'b1;
          wr_addr = idx + IDX_W'(1);
          wr_data = cmp.le ? key : rdata;
        end else if (op == MODE_REMOVE && found) begin
          wr_en   = 1'b1;
          wr_addr = idx - IDX_W'(1);
          wr_data = rdata;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[idx];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads on this edge
      if (rsp_valid && rsp.ready && state != S_RESULT) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= req.mode;
            key    <= req.value;
            found  <= 1'b0;
            pos    <= '0;
            unique case (req.mode)
              MODE_INSERT: begin
                if (occ >= CNT_W'(CAPACITY)) begin
                  status <= STATUS_FULL;
                  state  <= S_RESULT;
                end else if (occ == '0) begin
                  status <= STATUS_DONE;
                  state  <= S_PUT;
                end else begin
                  status <= STATUS_DONE;
                  idx    <= IDX_W'(occ - CNT_W'(1));
                  state  <= S_READ;
                end
              end
              MODE_FIND, MODE_REMOVE: begin
                if (occ == '0) begin
                  status <= STATUS_EMPTY;
                  state  <= S_RESULT;
                end else begin
                  status <= STATUS_DONE;
                  idx    <= '0;
                  state  <= S_READ;
                end
              end
              MODE_NOP: begin
                status <= STATUS_DONE;
                state  <= S_RESULT;
              end
            endcase
          end
        end

        S_READ: begin
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (op == MODE_INSERT) begin
            // key belongs just above this entry, or keep moving down
            if (cmp.le) begin
              pos   <= idx + IDX_W'(1);
              occ   <= occ + CNT_W'(1);
              state <= S_RESULT;
            end else if (idx == '0) begin
              state <= S_PUT;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_READ;
            end
          end else if (!found && cmp.eq) begin
            pos   <= idx;
            found <= 1'b1;
            if (op == MODE_FIND) begin
              state <= S_RESULT;
            end else if (last) begin
              occ   <= occ - CNT_W'(1);
              state <= S_RESULT;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end else if (last) begin
            if (found) begin
              occ <= occ - CNT_W'(1);
            end else begin
              status <= STATUS_ABSENT;
              pos    <= '0;
            end
            state <= S_RESULT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end

        S_PUT: begin
          pos   <= '0;
          occ   <= occ + CNT_W'(1);
          state <= S_RESULT;
        end

        S_RESULT: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_status   <= status;
            rsp_position <= POSITION_W'(pos);
            rsp_count    <= COUNT_W'(occ);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.position = rsp_position;
  assign rsp.count    = rsp_count;

  // occupancy never passes the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // one item at a time: after acceptance the unit is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while busy");

  // a failed operation reports position zero
  a_fail_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != STATUS_DONE) |-> (rsp_position == '0))
    else $error("nonzero position on failed operation");

  // a full insert reports the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_count == COUNT_W'(CAPACITY)))
    else $error("full status with table not full");

endmodule

`default_nettype wire
